### hw/rtl/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg
// Shared constants for the midpoint circle generator: default coordinate
// width, action codes, queue depth and the per-step pixel count.
// ----------------------------------------------------------------------------
package mcg_pkg;

    localparam int COORD_BITS_DEFAULT = 15;
    localparam int QUEUE_DEPTH        = 2;
    localparam int PIXELS_PER_STEP    = 8;
    localparam int PIX_IDX_BITS       = $clog2(PIXELS_PER_STEP);

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam logic [PIX_IDX_BITS-1:0] LAST_PIXEL = PIX_IDX_BITS'(PIXELS_PER_STEP - 1);

endpackage

### hw/rtl/mcg_front.sv
// ----------------------------------------------------------------------------
// mcg_front
// Accepts start and step transactions, holds the circle state and the
// midpoint decision variable, and pushes one octet job per active step.
// ----------------------------------------------------------------------------
module mcg_front #(
    parameter int COORD_BITS = mcg_pkg::COORD_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_accept,
    input  logic                      in_action,
    input  logic [COORD_BITS-1:0]     in_center_x,
    input  logic [COORD_BITS-1:0]     in_center_y,
    input  logic [COORD_BITS-2:0]     in_radius,
    output logic                      job_push,
    output logic [4*COORD_BITS:0]     job_data
);

    localparam int DEC_BITS = COORD_BITS + 3;

    logic [COORD_BITS-1:0] center_x_reg, center_x_next;
    logic [COORD_BITS-1:0] center_y_reg, center_y_next;
    logic [COORD_BITS-1:0] offset_x_reg, offset_x_next;
    logic [COORD_BITS-1:0] offset_y_reg, offset_y_next;
    logic [DEC_BITS-1:0]   decision_reg, decision_next;
    logic                  active_reg, active_next;

    logic                  done;
    logic [DEC_BITS-1:0]   dx, dy;

    assign done = !(offset_y_reg > offset_x_reg);
    assign dx   = DEC_BITS'(offset_x_reg);
    assign dy   = DEC_BITS'(offset_y_reg);

    assign job_push = in_accept && (in_action == mcg_pkg::ACT_STEP) && active_reg;
    assign job_data = {done, offset_y_reg, offset_x_reg, center_y_reg, center_x_reg};

    always_comb begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        offset_x_next = offset_x_reg;
        offset_y_next = offset_y_reg;
        decision_next = decision_reg;
        active_next   = active_reg;
        if (in_accept && (in_action == mcg_pkg::ACT_START)) begin
            center_x_next = in_center_x;
            center_y_next = in_center_y;
            offset_x_next = '0;
            offset_y_next = COORD_BITS'(in_radius);
            decision_next = DEC_BITS'(1) - DEC_BITS'(in_radius);
            active_next   = 1'b1;
        end else if (job_push) begin
            if (done) begin
                active_next = 1'b0;
            end else begin
                // negative decision: step east, else step south-east
                if (decision_reg[DEC_BITS-1]) begin
                    decision_next = decision_reg + (dx << 1) + DEC_BITS'(3);
                end else begin
                    decision_next = decision_reg + ((dx - dy) << 1) + DEC_BITS'(5);
                    offset_y_next = offset_y_reg - COORD_BITS'(1);
                end
                offset_x_next = offset_x_reg + COORD_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            decision_reg <= '0;
            active_reg   <= 1'b0;
        end else begin
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
            offset_x_reg <= offset_x_next;
            offset_y_reg <= offset_y_next;
            decision_reg <= decision_next;
            active_reg   <= active_next;
        end
    end

endmodule

### hw/rtl/mcg_queue.sv
// ----------------------------------------------------------------------------
// mcg_queue
// Small register queue carrying octet jobs from the front to the back.
// ----------------------------------------------------------------------------
module mcg_queue #(
    parameter int WIDTH = 61,
    parameter int DEPTH = mcg_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != CNT_BITS'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_BITS'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/mcg_back.sv
// ----------------------------------------------------------------------------
// mcg_back
// Walks one octet job through its eight symmetric pixels, one per cycle
// while out_ready allows, into a registered output stage.
// ----------------------------------------------------------------------------
module mcg_back #(
    parameter int COORD_BITS = mcg_pkg::COORD_BITS_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    job_valid,
    input  logic [4*COORD_BITS:0]   job_data,
    output logic                    job_pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [COORD_BITS:0]     out_pixel_x,
    output logic [COORD_BITS:0]     out_pixel_y,
    output logic                    out_last,
    output logic                    out_done
);

    localparam int PIX_BITS = COORD_BITS + 1;

    logic [mcg_pkg::PIX_IDX_BITS-1:0] idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    logic [PIX_BITS-1:0]   pixel_x_reg, pixel_y_reg;
    logic                  last_reg, done_reg;

    logic [COORD_BITS-1:0] h, k, ox, oy, a, b;
    logic                  done;
    logic [PIX_BITS-1:0]   hx, ky, ax, by, px, py;
    logic                  load;

    assign {done, oy, ox, k, h} = job_data;

    // pixels 4..7 swap the offsets; bit 0 negates x, bit 1 negates y
    assign a  = idx_reg[2] ? oy : ox;
    assign b  = idx_reg[2] ? ox : oy;
    assign hx = {h[COORD_BITS-1], h};
    assign ky = {k[COORD_BITS-1], k};
    assign ax = {1'b0, a};
    assign by = {1'b0, b};
    assign px = idx_reg[0] ? (hx - ax) : (hx + ax);
    assign py = idx_reg[1] ? (ky - by) : (ky + by);

    assign load    = job_valid && (!valid_reg || out_ready);
    assign job_pop = load && (idx_reg == mcg_pkg::LAST_PIXEL);

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = idx_reg + mcg_pkg::PIX_IDX_BITS'(1);
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
        if (load) begin
            pixel_x_reg <= px;
            pixel_y_reg <= py;
            last_reg    <= (idx_reg == mcg_pkg::LAST_PIXEL);
            done_reg    <= done;
        end
    end

    assign out_valid   = valid_reg;
    assign out_pixel_x = pixel_x_reg;
    assign out_pixel_y = pixel_y_reg;
    assign out_last    = last_reg;
    assign out_done    = done_reg;

endmodule

### hw/rtl/midpoint_circle_generator.sv
// ----------------------------------------------------------------------------
// midpoint_circle_generator
// Integer midpoint circle rasterizer with a streaming input of start/step
// transactions and a streaming output of pixels.
// ----------------------------------------------------------------------------
// usage:
//   s_axis: tuser = action (start or step), tdata = center_x, center_y,
//   radius. a start loads the circle and gives no pixels; each later step
//   gives eight symmetric pixels, then advances the decision variable.
//   steps after the final octet, or before any start, give nothing.
//   m_axis: tdata = pixel_x, pixel_y; tlast marks the eighth pixel of a
//   step; tuser marks every pixel of the final octet.
// path: the first pixel of a step is registered in the job queue, then
//   in the output register, when the back sequencer is free.
// throughput: one pixel per cycle from the back sequencer while m_axis_tready
//   is high; the front takes starts and steps each cycle while the
//   two-entry job queue has room.
// reset: aresetn (synchronous, active low) clears circle state, queue and
//   output stage; the block comes up idle.
// stall: when m_axis_tready is low the output register holds, the queue
//   fills, and s_axis_tready drops once both entries are in use.
// ----------------------------------------------------------------------------
module midpoint_circle_generator #(
    parameter int COORD_BITS = mcg_pkg::COORD_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input: center_x [C-1:0], center_y [2C-1:C], radius [3C-2:2C], zero pad
    input  logic [((3*COORD_BITS-1+7)/8)*8-1:0] s_axis_tdata,
    // input: action (0 start, 1 step)
    input  logic                          s_axis_tuser,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // output: pixel_x [C:0], pixel_y [2C+1:C+1], zero pad
    output logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_axis_tdata,
    // output: circle_done
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready
);

    localparam int PIX_BITS   = COORD_BITS + 1;
    localparam int JOB_BITS   = 4 * COORD_BITS + 1;
    localparam int OUT_W      = ((2*COORD_BITS+2+7)/8)*8;
    localparam int OUT_PAD    = OUT_W - 2*PIX_BITS;

    logic                  in_accept;
    logic                  job_push, job_ready, job_pop, job_valid;
    logic [JOB_BITS-1:0]   push_data, head_data;
    logic [PIX_BITS-1:0]   pixel_x, pixel_y;

    // the front can take any transaction while the job queue has room
    assign s_axis_tready = job_ready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    mcg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_action   (s_axis_tuser),
        .in_center_x (s_axis_tdata[COORD_BITS-1:0]),
        .in_center_y (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_radius   (s_axis_tdata[3*COORD_BITS-2:2*COORD_BITS]),
        .job_push    (job_push),
        .job_data    (push_data)
    );

    // decouples classification from pixel emission
    mcg_queue #(
        .WIDTH (JOB_BITS),
        .DEPTH (mcg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_push),
        .push_data  (push_data),
        .push_ready (job_ready),
        .pop        (job_pop),
        .head_valid (job_valid),
        .head_data  (head_data)
    );

    // eight pixels per job, one per cycle while the output is not stalled
    mcg_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (job_valid),
        .job_data    (head_data),
        .job_pop     (job_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_pixel_x (pixel_x),
        .out_pixel_y (pixel_y),
        .out_last    (m_axis_tlast),
        .out_done    (m_axis_tuser)
    );

    generate
        if (OUT_PAD > 0) begin : g_pad
            assign m_axis_tdata = {{OUT_PAD{1'b0}}, pixel_y, pixel_x};
        end else begin : g_nopad
            assign m_axis_tdata = {pixel_y, pixel_x};
        end
    endgenerate

    // a job is only pushed when the queue has room
    assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |-> job_ready)
        else $error("job pushed into a full queue");

    // pixels of one octet all carry the same done flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) ##1 m_axis_tvalid
        |-> (m_axis_tuser == $past(m_axis_tuser)))
        else $error("done flag changed inside an octet");

    // output stage comes out of reset empty
    assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

### tb/midpoint_circle_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_generator_tb
// Drives start and step transactions into the circle rasterizer and checks
// every pixel against a cycle-free predictor of the midpoint algorithm.
// A short table covers reset behavior, coordinate extremes, zero radius and
// restarts; random circles follow, with random stalls on both streams.
// ----------------------------------------------------------------------------
module midpoint_circle_generator_tb;

    localparam int CB        = mcg_pkg::COORD_BITS_DEFAULT; // coordinate width
    localparam int RB        = CB - 1;                      // radius width
    localparam int PB        = CB + 1;                      // pixel width
    localparam int DB        = CB + 3;                      // decision width
    localparam int IN_W      = ((3*CB-1+7)/8)*8;
    localparam int OUT_W     = ((2*CB+2+7)/8)*8;
    localparam int RAND_ITEMS = 380;
    localparam int SMALL_RAD = 24;                          // keeps full circles short
    localparam int MAX_SHOWN = 10;
    localparam int DIR_N     = 24;

    // one expected pixel, in the order it must leave the block
    typedef struct packed {
        logic signed [PB-1:0] px;
        logic signed [PB-1:0] py;
        logic                 last;
        logic                 done;
    } pixel_t;

    // one row of the directed table; typed rows carry the count and first pixel
    typedef struct packed {
        logic                 act;
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] cy;
        logic [CB-2:0]        rad;
        logic                 typed;
        logic [3:0]           n;
        logic signed [PB-1:0] px;
        logic signed [PB-1:0] py;
        logic                 done;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIR_N] = '{
        // step before any start: ignored
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b1, 4'd0,      0,      0, 1'b0},
        // zero radius at the origin, one octet at the center, then ignored
        '{mcg_pkg::ACT_START,      0,      0,     0, 1'b1, 4'd0,      0,      0, 1'b0},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b1, 4'd8,      0,      0, 1'b1},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b1, 4'd0,      0,      0, 1'b0},
        // largest center and radius
        '{mcg_pkg::ACT_START,  16383,  16383, 16383, 1'b1, 4'd0,      0,      0, 1'b0},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b1, 4'd8,  16383,  32766, 1'b0},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b0, 4'd0,      0,      0, 1'b0},
        // most negative center, largest radius, restarted mid-circle
        '{mcg_pkg::ACT_START, -16384, -16384, 16383, 1'b1, 4'd0,      0,      0, 1'b0},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b1, 4'd8, -16384,     -1, 1'b0},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b0, 4'd0,      0,      0, 1'b0},
        // radius one, restart while the previous circle is still open
        '{mcg_pkg::ACT_START,     -1,      1,     1, 1'b1, 4'd0,      0,      0, 1'b0},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b1, 4'd8,     -1,      2, 1'b0},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b1, 4'd8,      0,      1, 1'b1},
        // radius five, both decision branches, run to the end
        '{mcg_pkg::ACT_START,    100,   -200,     5, 1'b0, 4'd0,      0,      0, 1'b0},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b0, 4'd0,      0,      0, 1'b0},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b0, 4'd0,      0,      0, 1'b0},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b0, 4'd0,      0,      0, 1'b0},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b0, 4'd0,      0,      0, 1'b0},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b0, 4'd0,      0,      0, 1'b0},
        // radius two at a mixed corner
        '{mcg_pkg::ACT_START,  16383, -16384,     2, 1'b0, 4'd0,      0,      0, 1'b0},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b0, 4'd0,      0,      0, 1'b0},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b0, 4'd0,      0,      0, 1'b0},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b0, 4'd0,      0,      0, 1'b0},
        '{mcg_pkg::ACT_STEP,       0,      0,     0, 1'b1, 4'd0,      0,      0, 1'b0}
    };

    // clock, reset and the two streams
    logic              aclk;
    logic              aresetn;
    logic [IN_W-1:0]   s_axis_tdata;   // center_x, center_y, radius, zero pad
    logic              s_axis_tuser;   // action
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;   // pixel_x, pixel_y
    logic              m_axis_tuser;   // circle_done
    logic              m_axis_tlast;   // last pixel of the octet
    logic              m_axis_tvalid;
    logic              m_axis_tready;

    // circle predictor state
    logic signed [CB-1:0] ctr_x, ctr_y;
    logic [CB-1:0]        ofs_x, ofs_y;
    logic signed [DB-1:0] dec_var;
    logic                 circle_on;
    pixel_t               octet_pix [8];

    pixel_t pix_expected [$];

    // bookkeeping
    int err_count;
    int items_sent;
    int starts_sent;
    int pixels_checked;
    int circles_closed;
    int drains;
    logic snd_burst, rcv_burst;

    midpoint_circle_generator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // advance the circle by one transaction, fill octet_pix, return pixel count
    function automatic int rasterize_item(input logic act, input logic signed [CB-1:0] cx,
                                          input logic signed [CB-1:0] cy,
                                          input logic [CB-2:0] rad);
        int  h, k, x, y, d, r;
        logic fin;
        if (act == mcg_pkg::ACT_START) begin
            r         = int'(rad);
            ctr_x     = cx;
            ctr_y     = cy;
            ofs_x     = '0;
            ofs_y     = CB'(r);
            dec_var   = DB'(1 - r);
            circle_on = 1'b1;
            return 0;
        end
        if (!circle_on) return 0;

        h   = int'(ctr_x);
        k   = int'(ctr_y);
        x   = int'(ofs_x);
        y   = int'(ofs_y);
        fin = !(y > x);
        octet_pix[0] = '{PB'(h + x), PB'(k + y), 1'b0, fin};
        octet_pix[1] = '{PB'(h - x), PB'(k + y), 1'b0, fin};
        octet_pix[2] = '{PB'(h + x), PB'(k - y), 1'b0, fin};
        octet_pix[3] = '{PB'(h - x), PB'(k - y), 1'b0, fin};
        octet_pix[4] = '{PB'(h + y), PB'(k + x), 1'b0, fin};
        octet_pix[5] = '{PB'(h - y), PB'(k + x), 1'b0, fin};
        octet_pix[6] = '{PB'(h + y), PB'(k - x), 1'b0, fin};
        octet_pix[7] = '{PB'(h - y), PB'(k - x), 1'b1, fin};

        if (fin) begin
            circle_on = 1'b0;
        end else begin
            d = int'(dec_var);
            // midpoint inside: stay on this row; outside: step y inward
            if (d < 0) begin
                d = d + 2*x + 3;
            end else begin
                d = d + 2*(x - y) + 5;
                y = y - 1;
            end
            x       = x + 1;
            dec_var = DB'(d);
            ofs_x   = CB'(x);
            ofs_y   = CB'(y);
        end
        return 8;
    endfunction

    function automatic int draw_gap(inout logic burst);
        if ($urandom_range(0, 29) == 0) burst = ~burst;
        return burst ? 0 : $urandom_range(0, 14);
    endfunction

    // drive one input transaction, wait for it to be taken, then queue its pixels
    task automatic send_item(input logic act, input logic signed [CB-1:0] cx,
                             input logic signed [CB-1:0] cy, input logic [CB-2:0] rad,
                             input logic typed, input int typed_n, input pixel_t typed_pix);
        int gap;
        int n;
        gap = draw_gap(snd_burst);
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata  <= IN_W'({rad, cy, cx});
        s_axis_tuser  <= act;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);

        n = rasterize_item(act, cx, cy, rad);
        if (typed) begin
            // table values stand in for the first pixel and the count
            n = typed_n;
            if (n > 0) begin
                octet_pix[0].px   = typed_pix.px;
                octet_pix[0].py   = typed_pix.py;
                octet_pix[0].done = typed_pix.done;
            end
        end
        for (int i = 0; i < n; i++) pix_expected.push_back(octet_pix[i]);
        items_sent++;
        if (act == mcg_pkg::ACT_START) starts_sent++;
    endtask

    task automatic send_random(input logic act, input logic [CB-2:0] rad);
        send_item(act, CB'($urandom_range(0, (1 << CB) - 1)),
                  CB'($urandom_range(0, (1 << CB) - 1)), rad, 1'b0, 0, '0);
    endtask

    // hold the input stream idle until every queued pixel has come out
    task automatic drain_pixels();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pix_expected.size() != 0) @(posedge aclk);
        drains++;
    endtask

    // sender
    initial begin
        pixel_t tp;
        int     pick;
        aresetn       = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = mcg_pkg::ACT_START;
        s_axis_tvalid = 1'b0;
        err_count     = 0;
        items_sent    = 0;
        starts_sent   = 0;
        drains        = 0;
        snd_burst     = 1'b0;
        void'(rasterize_item(mcg_pkg::ACT_START, '0, '0, '0));
        // predictor starts from the reset state: idle, all zero
        ctr_x = '0; ctr_y = '0; ofs_x = '0; ofs_y = '0; dec_var = '0; circle_on = 1'b0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_N; i++) begin
            tp = '{DIRECTED[i].px, DIRECTED[i].py, 1'b0, DIRECTED[i].done};
            send_item(DIRECTED[i].act, DIRECTED[i].cx, DIRECTED[i].cy, DIRECTED[i].rad,
                      DIRECTED[i].typed, int'(DIRECTED[i].n), tp);
        end
        drain_pixels();

        // random circles: mostly complete ones, some abandoned, some noise
        while (items_sent < DIR_N + RAND_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                send_random(mcg_pkg::ACT_START, RB'($urandom_range(0, SMALL_RAD)));
                while (circle_on)
                    send_random(mcg_pkg::ACT_STEP, RB'($urandom_range(0, (1 << RB) - 1)));
                repeat ($urandom_range(0, 2))
                    send_random(mcg_pkg::ACT_STEP, RB'($urandom_range(0, (1 << RB) - 1)));
            end else if (pick < 15) begin
                // full-width radius, dropped after a few octets by the next start
                send_random(mcg_pkg::ACT_START, RB'($urandom_range(0, (1 << RB) - 1)));
                repeat ($urandom_range(1, 6))
                    send_random(mcg_pkg::ACT_STEP, RB'($urandom_range(0, (1 << RB) - 1)));
            end else if (pick < 19) begin
                repeat ($urandom_range(1, 4))
                    send_random(logic'($urandom_range(0, 1)),
                                RB'($urandom_range(0, (1 << RB) - 1)));
            end else begin
                drain_pixels();
            end
        end

        drain_pixels();
        repeat (32) @(posedge aclk);
        $display("covered %0d transactions (%0d starts), %0d pixels checked",
                 items_sent, starts_sent, pixels_checked);
        $display("%0d circles closed, input stream fully drained %0d times, %0d failures",
                 circles_closed, drains, err_count);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // receiver: random back-pressure per pixel, compare in order
    initial begin
        pixel_t want;
        pixel_t got;
        int     gap;
        m_axis_tready  = 1'b0;
        pixels_checked = 0;
        circles_closed = 0;
        rcv_burst      = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = draw_gap(rcv_burst);
            @(negedge aclk);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);

            got = '{m_axis_tdata[PB-1:0], m_axis_tdata[2*PB-1:PB], m_axis_tlast, m_axis_tuser};
            if (pix_expected.size() == 0) begin
                err_count++;
                if (err_count <= MAX_SHOWN)
                    $display("unexpected pixel x=%0d y=%0d last=%0b done=%0b",
                             $signed(got.px), $signed(got.py), got.last, got.done);
            end else begin
                want = pix_expected.pop_front();
                pixels_checked++;
                if (want.last && want.done) circles_closed++;
                if (got !== want) begin
                    err_count++;
                    if (err_count <= MAX_SHOWN)
                        $display({"pixel mismatch: expected x=%0d y=%0d last=%0b done=%0b,",
                                  " got x=%0d y=%0d last=%0b done=%0b"},
                                 $signed(want.px), $signed(want.py), want.last, want.done,
                                 $signed(got.px), $signed(got.py), got.last, got.done);
                end
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #8000000;
        $display("timeout with %0d pixels still expected", pix_expected.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
